// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the span generator RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RGSG_ASSERT_IMPL(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("rgsg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RGSG_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("rgsg: next-cycle check failed");

`endif

// ===== hdl/rgsg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the span generator.
// No dependencies; used by every module of the block.
`default_nettype none

package rgsg_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ROW_W   = 15;
  localparam int CRD_W   = 16;
  localparam int DIM_W   = 15;
  localparam int RAD_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 16;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;
  localparam int LIM_W   = 16;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_PLATE_WIDTH  = 3'd2,
    REG_PLATE_HEIGHT = 3'd3,
    REG_RADIUS       = 3'd4,
    REG_TOP_COLOR    = 3'd5,
    REG_BOTTOM_COLOR = 3'd6,
    REG_OPACITY      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CRD_W-1:0]   origin_x;
    logic [CRD_W-1:0]   origin_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] top_color;
    logic [COLOR_W-1:0] bottom_color;
    logic [7:0]         opacity;
  } cfg_t;

  // One classified row as it waits between front and back.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             empty;   // no span for this row
    logic             corner;  // row lies in a rounded corner band
    logic [RAD_W-1:0] rad;     // clamped corner radius
    logic [LIM_W-1:0] lim;     // r*r - dy*dy for the inset search
  } entry_t;

  // Result payload; the first member sits in the highest bits, so span_x ends up lowest.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [DIM_W-1:0]  span_width;
    logic [CRD_W-1:0]  span_y;
    logic [CRD_W-1:0]  span_x;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Floor of num / 255 for num below 255 * 2^16. The estimate num*257 >> 16 is never
  // high and at most one low, so one compare and increment finishes it.
  function automatic logic [15:0] div255(input logic [23:0] num);
    logic [31:0] scaled;
    logic [15:0] est;
    logic [24:0] rem;
    scaled = {num, 8'b0} + {8'b0, num};
    est    = scaled[31:16];
    rem    = {1'b0, num} - ({1'b0, est, 8'b0} - {9'b0, est});
    if (rem >= 25'd255) begin
      est = est + 16'd1;
    end
    return est;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rgsg_front.sv =====
// Front end: accepts row words, clamps the corner radius and classifies each row.
// Depends on rgsg_pkg; feeds rgsg_queue.
`default_nettype none

module rgsg_front (
  input  wire rgsg_pkg::cfg_t              cfg,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [rgsg_pkg::ROW_W-1:0]  in_row,
  input  wire logic                        q_full,
  output logic                             push,
  output rgsg_pkg::entry_t                 entry
);

  logic [rgsg_pkg::DIM_W-1:0] half_w;
  logic [rgsg_pkg::DIM_W-1:0] half_h;
  logic [rgsg_pkg::DIM_W-1:0] r_clamp;
  logic [rgsg_pkg::DIM_W-1:0] rc_ext;
  logic [rgsg_pkg::DIM_W-1:0] dy_ext;
  logic [rgsg_pkg::RAD_W-1:0] rc;
  logic [rgsg_pkg::RAD_W-1:0] dy;
  logic [rgsg_pkg::LIM_W-1:0] rsq;
  logic [rgsg_pkg::LIM_W-1:0] dysq;
  logic                       empty;
  logic                       top_band;
  logic                       bot_band;
  logic                       corner;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    half_w  = {1'b0, cfg.width[rgsg_pkg::DIM_W-1:1]};
    half_h  = {1'b0, cfg.height[rgsg_pkg::DIM_W-1:1]};
    r_clamp = {7'b0, cfg.radius};
    if (r_clamp > half_w) begin
      r_clamp = half_w;
    end
    if (r_clamp > half_h) begin
      r_clamp = half_h;
    end
    rc     = r_clamp[rgsg_pkg::RAD_W-1:0];
    rc_ext = {7'b0, rc};

    empty    = (cfg.width == '0) || (cfg.height == '0) || (in_row >= cfg.height);
    top_band = in_row < rc_ext;
    bot_band = in_row >= (cfg.height - rc_ext);
    corner   = !empty && (rc != '0) && (top_band || bot_band);

    // Distance from the corner center row, counted toward the plate edge.
    if (top_band) begin
      dy_ext = rc_ext - in_row;
    end else begin
      dy_ext = rc_ext - (cfg.height - 15'd1 - in_row);
    end
    dy   = dy_ext[rgsg_pkg::RAD_W-1:0];
    rsq  = rc * rc;
    dysq = dy * dy;

    entry.row    = in_row;
    entry.empty  = empty;
    entry.corner = corner;
    entry.rad    = rc;
    entry.lim    = corner ? (rsq - dysq) : '0;
  end

endmodule

`default_nettype wire

// ===== hdl/rgsg_queue.sv =====
// Short queue of classified rows between the front end and the back end.
// Depends on rgsg_pkg for the entry type.
`default_nettype none

module rgsg_queue #(
  parameter int DEPTH = rgsg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rgsg_pkg::entry_t din,
  output logic                  full,
  input  wire logic             pop,
  output rgsg_pkg::entry_t      dout,
  output logic                  valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rgsg_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rgsg_back.sv =====
// Back end: sequencer that finds the corner inset, the gradient position and the
// premultiplied color of one row, around a single shared 8x8 multiplier. Uses rgsg_pkg.
`default_nettype none

module rgsg_back #(
  parameter int COORD_BITS = rgsg_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rgsg_pkg::cfg_t   cfg,
  input  wire logic             q_valid,
  input  wire rgsg_pkg::entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output rgsg_pkg::res_t        out_res,
  output logic                  out_empty
);

  localparam int REM_W = rgsg_pkg::ROW_W + 8;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_MIXMUL = 7'b0000100,
    ST_MIXDIV = 7'b0001000,
    ST_PMMUL  = 7'b0010000,
    ST_PMDIV  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } st_t;

  st_t                          state_r, state_nxt;
  rgsg_pkg::entry_t             ent_r, ent_nxt;
  logic [2:0]                   bit_r, bit_nxt;
  logic [7:0]                   e_r, e_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [7:0]                   t_r, t_nxt;
  logic [1:0]                   ch_r, ch_nxt;
  logic [15:0]                  prod_r, prod_nxt;
  logic                         neg_r, neg_nxt;
  logic [7:0]                   c_r, c_nxt;
  logic [15:0]                  red_r, red_nxt;
  logic [15:0]                  green_r, green_nxt;
  logic [15:0]                  blue_r, blue_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic                         out_empty_r, out_empty_nxt;
  rgsg_pkg::res_t               out_res_r, out_res_nxt;

  logic [7:0]                   mul_a;
  logic [7:0]                   mul_b;
  logic [15:0]                  mul_p;
  logic [7:0]                   trial;
  logic [REM_W-1:0]             dvs_sh;
  logic [rgsg_pkg::DIM_W-1:0]   dvs;
  logic [7:0]                   top_ch;
  logic [7:0]                   bot_ch;
  logic [7:0]                   absd;
  logic [15:0]                  mix_q;
  logic [15:0]                  pm;
  logic [7:0]                   inset;
  logic [rgsg_pkg::CRD_W-1:0]   xs;
  logic [rgsg_pkg::CRD_W-1:0]   ys;
  logic [rgsg_pkg::CRD_W-1:0]   xw;
  logic [rgsg_pkg::CRD_W-1:0]   yw;

  assign out_tvalid = out_tvalid_r;
  assign out_res    = out_res_r;
  assign out_empty  = out_empty_r;

  // Channel under work: red, then green, then blue.
  always_comb begin
    case (ch_r)
      2'd0: begin
        top_ch = cfg.top_color[23:16];
        bot_ch = cfg.bottom_color[23:16];
      end
      2'd1: begin
        top_ch = cfg.top_color[15:8];
        bot_ch = cfg.bottom_color[15:8];
      end
      default: begin
        top_ch = cfg.top_color[7:0];
        bot_ch = cfg.bottom_color[7:0];
      end
    endcase
    absd = (bot_ch >= top_ch) ? (bot_ch - top_ch) : (top_ch - bot_ch);
  end

  assign trial  = e_r | (8'd1 << bit_r);
  assign dvs    = cfg.height - 15'd1;
  assign dvs_sh = {8'b0, dvs} << bit_r;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      ST_SEARCH: begin
        mul_a = trial;
        mul_b = trial;
      end
      ST_MIXMUL: begin
        mul_a = absd;
        mul_b = t_r;
      end
      ST_PMMUL: begin
        mul_a = c_r;
        mul_b = cfg.opacity;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign mix_q = rgsg_pkg::div255({8'b0, prod_r});
  assign pm    = rgsg_pkg::div255({prod_r, 8'b0} + {8'b0, prod_r});

  // Span geometry, wrapped to COORD_BITS signed and widened back to 16 bits.
  always_comb begin
    inset = ent_r.corner ? (ent_r.rad - e_r) : '0;
    xs    = cfg.origin_x + {8'b0, inset};
    ys    = cfg.origin_y + {1'b0, ent_r.row};
    for (int i = 0; i < rgsg_pkg::CRD_W; i++) begin
      xw[i] = (i < COORD_BITS) ? xs[i] : xs[COORD_BITS-1];
      yw[i] = (i < COORD_BITS) ? ys[i] : ys[COORD_BITS-1];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ent_nxt        = ent_r;
    bit_nxt        = bit_r;
    e_nxt          = e_r;
    rem_nxt        = rem_r;
    t_nxt          = t_r;
    ch_nxt         = ch_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    c_nxt          = c_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    out_res_nxt    = out_res_r;
    out_empty_nxt  = out_empty_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    q_pop          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ent_nxt   = q_entry;
          bit_nxt   = 3'd7;
          e_nxt     = '0;
          t_nxt     = '0;
          ch_nxt    = '0;
          rem_nxt   = {q_entry.row, 8'b0} - {8'b0, q_entry.row};
          state_nxt = q_entry.empty ? ST_DONE : ST_SEARCH;
        end
      end

      // One quotient bit of row*255/(h-1) and one bit of the inset root per cycle.
      ST_SEARCH: begin
        if (mul_p <= ent_r.lim) begin
          e_nxt = trial;
        end
        if (rem_r >= dvs_sh) begin
          rem_nxt = rem_r - dvs_sh;
          t_nxt   = t_r | (8'd1 << bit_r);
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          // A single-row plate takes the top color.
          if (cfg.height == 15'd1) begin
            t_nxt = '0;
          end
          state_nxt = ST_MIXMUL;
        end
      end

      ST_MIXMUL: begin
        prod_nxt  = mul_p;
        neg_nxt   = bot_ch < top_ch;
        state_nxt = ST_MIXDIV;
      end

      // Quotient truncates toward zero, so the mix stays between both ends.
      ST_MIXDIV: begin
        c_nxt     = neg_r ? (top_ch - mix_q[7:0]) : (top_ch + mix_q[7:0]);
        state_nxt = ST_PMMUL;
      end

      ST_PMMUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_PMDIV;
      end

      ST_PMDIV: begin
        case (ch_r)
          2'd0:    red_nxt   = pm;
          2'd1:    green_nxt = pm;
          default: blue_nxt  = pm;
        endcase
        if (ch_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_MIXMUL;
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_empty_nxt  = ent_r.empty;
          if (ent_r.empty) begin
            out_res_nxt = '0;
          end else begin
            out_res_nxt.span_x     = xw;
            out_res_nxt.span_y     = yw;
            out_res_nxt.span_width = cfg.width - {6'b0, inset, 1'b0};
            out_res_nxt.red        = red_r;
            out_res_nxt.green      = green_r;
            out_res_nxt.blue       = blue_r;
            out_res_nxt.alpha      = {cfg.opacity, cfg.opacity};
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    bit_r       <= bit_nxt;
    e_r         <= e_nxt;
    rem_r       <= rem_nxt;
    t_r         <= t_nxt;
    ch_r        <= ch_nxt;
    prod_r      <= prod_nxt;
    neg_r       <= neg_nxt;
    c_r         <= c_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    out_res_r   <= out_res_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/rounded_gradient_span_generator.sv =====
// Top level of the rounded-plate span generator: configuration registers,
// front end, row queue and back-end sequencer. Uses rgsg_pkg and assert_macros.svh.
//
// Usage. Program the plate through the cfg_ write port (one register per
// write, applied at the clock edge where cfg_we is high) while the block is
// idle. Then send row indices on the in_ stream; each accepted word yields
// exactly one word on the out_ stream, in order. out_tuser is high when the
// row is outside the plate or the plate is empty; all tdata bits are then 0.
// The back end takes one row at a time and fetches the next only after its
// result has gone to the output register. For a row with a span it runs an
// 8-step search (inset root and gradient quotient side by side) and then four
// steps per color channel around one shared 8x8 multiplier; an empty row skips
// these steps and goes straight to the result.
// A default two-entry queue lets the front end take new rows while the back end
// works, and the output register keeps the back end going while a result
// waits. When the receiver holds out_tready low, the result holds, the back
// end parks on its next result, and in_tready drops once the queue is full.
// Reset (rst_n low at a clock edge) empties the queue and the output, and returns
// the configuration registers to zero except the opacity, which resets to 255.
`default_nettype none
`include "assert_macros.svh"

module rounded_gradient_span_generator #(
  parameter int COORD_BITS  = rgsg_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = rgsg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration write port.
  input  wire logic                        cfg_we,
  input  wire logic [rgsg_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [rgsg_pkg::CFG_W-1:0]  cfg_wdata,
  // Input stream.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [15:0]                 in_tdata,   // [14:0] row, [15] zero
  // Result stream.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [15:0] span_x, [31:16] span_y, [46:32] span_width, [62:47] red,
  // [78:63] green, [94:79] blue, [110:95] alpha, [111] zero
  output logic [111:0]                     out_tdata,
  output logic [0:0]                       out_tuser   // [0] empty_res
);

  rgsg_pkg::cfg_t   cfg_r, cfg_nxt;
  rgsg_pkg::entry_t f_entry;
  rgsg_pkg::entry_t q_entry;
  rgsg_pkg::res_t   b_res;
  logic             f_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             b_empty;

  // Register writes; an index outside the list cannot occur with eight registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (rgsg_pkg::reg_idx_t'(cfg_index))
        rgsg_pkg::REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_wdata[15:0];
        rgsg_pkg::REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_wdata[15:0];
        rgsg_pkg::REG_PLATE_WIDTH:  cfg_nxt.width        = cfg_wdata[14:0];
        rgsg_pkg::REG_PLATE_HEIGHT: cfg_nxt.height       = cfg_wdata[14:0];
        rgsg_pkg::REG_RADIUS:       cfg_nxt.radius       = cfg_wdata[7:0];
        rgsg_pkg::REG_TOP_COLOR:    cfg_nxt.top_color    = cfg_wdata[23:0];
        rgsg_pkg::REG_BOTTOM_COLOR: cfg_nxt.bottom_color = cfg_wdata[23:0];
        rgsg_pkg::REG_OPACITY:      cfg_nxt.opacity      = cfg_wdata[7:0];
        default:                    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x: '0, origin_y: '0, width: '0, height: '0, radius: '0,
                 top_color: '0, bottom_color: '0, opacity: 8'hff};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rgsg_front u_front (
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_row    (in_tdata[14:0]),
    .q_full    (q_full),
    .push      (f_push),
    .entry     (f_entry)
  );

  rgsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_entry),
    .valid (q_valid)
  );

  rgsg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (b_res),
    .out_empty  (b_empty)
  );

  assign out_tdata = {1'b0, b_res};
  assign out_tuser = b_empty;

  // A full queue must stall the input side, or a row would be dropped.
  `RGSG_ASSERT_IMPL(a_full_stalls_input, clk, rst_n, q_full, !in_tready)
  // An empty-span word carries no geometry and no color.
  `RGSG_ASSERT_IMPL(a_empty_is_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  // A span never reaches past the plate's width.
  `RGSG_ASSERT_IMPL(a_span_in_plate, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[46:32] <= cfg_r.width)
  // The back end only pops when it has something to pop.
  `RGSG_ASSERT_IMPL(a_pop_has_data, clk, rst_n, q_pop, q_valid)

endmodule

`default_nettype wire
